/* rtl/core/sha1bc_pkg.sv */
// Package for the SHA-1 block compression engine.
// Holds the transaction types, queue sizing, round constants and round helpers.
// No dependencies.
package sha1bc_pkg;

	localparam int WORDS_PER_BLOCK = 16;
	localparam int ROUNDS          = 80;
	localparam int DIGEST_WORDS    = 5;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W          = QPTR_W + 1;

	localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
	localparam logic [2:0] LAST_DIGEST = 3'(DIGEST_WORDS - 1);
	localparam logic [3:0] LAST_WORD_POS = 4'(WORDS_PER_BLOCK - 1);

	// Round group boundaries
	localparam logic [6:0] ROUND_B1 = 7'd20;
	localparam logic [6:0] ROUND_B2 = 7'd40;
	localparam logic [6:0] ROUND_B3 = 7'd60;

	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

	localparam logic [31:0] IV [DIGEST_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	// Input transaction
	typedef struct packed {
		logic [31:0] message_word;
		logic        first_block;
		logic        final_block;
	} in_t;

	// Output transaction
	typedef struct packed {
		logic [31:0] digest_word;
		logic        last_word;
	} out_t;

	// Queue entry: one message word, classified by the front end
	typedef struct packed {
		logic [31:0] word;
		logic        blk_end;
		logic        first;
		logic        final_blk;
	} q_entry_t;

	// Queue status toward its neighbors
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] x,
		input logic [31:0] y, input logic [31:0] z);
		logic [31:0] r;
		if (t < ROUND_B1)
			r = (x & y) ^ (~x & z);
		else if (t < ROUND_B2)
			r = x ^ y ^ z;
		else if (t < ROUND_B3)
			r = (x & y) ^ (x & z) ^ (y & z);
		else
			r = x ^ y ^ z;
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] t);
		logic [31:0] r;
		if (t < ROUND_B1)
			r = K0;
		else if (t < ROUND_B2)
			r = K1;
		else if (t < ROUND_B3)
			r = K2;
		else
			r = K3;
		return r;
	endfunction

endpackage

/* rtl/core/sha1bc_front.sv */
// Front end: accepts message words, tracks position in the block and the
// block flags, and pushes classified entries into the queue. Uses sha1bc_pkg.
module sha1bc_front import sha1bc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_t       in_data,
	input  q_status_t q_status,
	output logic      push,
	output q_entry_t  push_entry
);

	logic [3:0] word_cnt_q;
	logic       first_q;
	logic       final_q;

	assign in_ready = !q_status.full;
	assign push     = in_valid && in_ready;

	// Classify the word; flags are ORed over the block
	always_comb begin
		push_entry.word      = in_data.message_word;
		push_entry.blk_end   = (word_cnt_q == LAST_WORD_POS);
		push_entry.first     = first_q | in_data.first_block;
		push_entry.final_blk = final_q | in_data.final_block;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_cnt_q <= '0;
			first_q    <= 1'b0;
			final_q    <= 1'b0;
		end else if (push) begin
			word_cnt_q <= word_cnt_q + 4'd1;
			if (push_entry.blk_end) begin
				first_q <= 1'b0;
				final_q <= 1'b0;
			end else begin
				first_q <= push_entry.first;
				final_q <= push_entry.final_blk;
			end
		end
	end

endmodule

/* rtl/core/sha1bc_fifo.sv */
// Short register queue between front and back end.
// Uses sha1bc_pkg for entry type and depth.
module sha1bc_fifo import sha1bc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  push_entry,
	input  logic      pop,
	output q_entry_t  head,
	output q_status_t status
);

	q_entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full)) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && status.empty)) else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

/* rtl/core/sha1bc_back.sv */
// Back end: loads the schedule window from the queue, runs 80 rounds at one
// per cycle, folds into the chaining value and emits the digest. Uses sha1bc_pkg.
module sha1bc_back import sha1bc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_entry_t  head,
	input  q_status_t q_status,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_t      out_data
);

	typedef enum logic [3:0] {
		S_LOAD  = 4'b0001,
		S_ROUND = 4'b0010,
		S_ADD   = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t      state_q;
	logic [6:0]  round_q;
	logic [2:0]  out_idx_q;
	logic        final_q;
	logic        out_valid_q;
	out_t        out_q;
	logic [31:0] cv_q  [DIGEST_WORDS];
	logic [31:0] wv_q  [DIGEST_WORDS];
	logic [31:0] win_q [WORDS_PER_BLOCK];

	logic [31:0] w_next;
	logic [31:0] w_exp;
	logic [31:0] temp;
	logic        out_load;

	assign pop       = (state_q == S_LOAD) && !q_status.empty;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Schedule expansion and round datapath
	always_comb begin
		w_exp  = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
		w_next = {w_exp[30:0], w_exp[31]};
		temp   = {wv_q[0][26:0], wv_q[0][31:27]}
			+ round_f(round_q, wv_q[1], wv_q[2], wv_q[3])
			+ wv_q[4] + round_k(round_q) + win_q[0];
	end

	// Schedule window shift line
	always_ff @(posedge clk) begin
		if (pop || state_q == S_ROUND) begin
			for (int i = 0; i < WORDS_PER_BLOCK - 1; i++)
				win_q[i] <= win_q[i+1];
			win_q[WORDS_PER_BLOCK-1] <= pop ? head.word : w_next;
		end
	end

	// Working variables
	always_ff @(posedge clk) begin
		if (pop && head.blk_end) begin
			for (int i = 0; i < DIGEST_WORDS; i++)
				wv_q[i] <= head.first ? IV[i] : cv_q[i];
		end else if (state_q == S_ROUND) begin
			wv_q[4] <= wv_q[3];
			wv_q[3] <= wv_q[2];
			wv_q[2] <= {wv_q[1][1:0], wv_q[1][31:2]};
			wv_q[1] <= wv_q[0];
			wv_q[0] <= temp;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.digest_word <= cv_q[out_idx_q];
			out_q.last_word   <= (out_idx_q == LAST_DIGEST);
		end
	end

	// Control and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			round_q     <= '0;
			out_idx_q   <= '0;
			final_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DIGEST_WORDS; i++)
				cv_q[i] <= IV[i];
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					if (pop && head.blk_end) begin
						if (head.first) begin
							for (int i = 0; i < DIGEST_WORDS; i++)
								cv_q[i] <= IV[i];
						end
						final_q <= head.final_blk;
						round_q <= '0;
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					round_q <= round_q + 7'd1;
					if (round_q == LAST_ROUND)
						state_q <= S_ADD;
				end
				S_ADD: begin
					for (int i = 0; i < DIGEST_WORDS; i++)
						cv_q[i] <= cv_q[i] + wv_q[i];
					out_idx_q <= '0;
					state_q   <= final_q ? S_OUT : S_LOAD;
				end
				S_OUT: begin
					if (out_load) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == LAST_DIGEST)
							state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_pop_only_loading: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == S_LOAD) else $error("queue popped outside load");
	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROUND |-> round_q <= LAST_ROUND) else $error("round index overrun");
	a_round_to_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && round_q == LAST_ROUND) |=> state_q == S_ADD)
		else $error("compression did not finish after last round");
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_idx_q <= LAST_DIGEST) else $error("digest index overrun");
`endif

endmodule

/* rtl/core/sha1_block_compress.sv */
// SHA-1 block compression engine, top level.
// Uses sha1bc_pkg, sha1bc_front, sha1bc_fifo and sha1bc_back.
//
// Usage: the input channel (in_valid/in_ready/in_data) takes padded message
// words, sixteen per 512-bit block; first_block on any word of a block reloads
// the initial chaining value, final_block on any word makes the engine emit
// the five digest words (H0 first, last_word on H4) on the output channel
// (out_valid/out_ready/out_data) after that block is compressed.
// The back end works on one block at a time: it loads the sixteen words from
// the queue, runs the rounds in the single round unit, folds the result into
// the chaining value and, for a final block, emits the digest words; it takes
// no words of the next block from the queue until all of this is done.
// A four-entry queue lets the front accept words while the back compresses.
// Reset (arst_n low) empties the queue, clears block position and flags and
// loads the standard initial chaining value. When the receiver stalls, the
// digest is held in the output register and the back end waits; the front
// keeps accepting until the queue fills.
module sha1_block_compress import sha1bc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	q_status_t q_status;
	q_entry_t  push_entry;
	q_entry_t  head;
	logic      push;
	logic      pop;

	sha1bc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	sha1bc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	sha1bc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
